// File: rtl/pcfd_pkg.sv
// Shared types and constants for the pulse capture frame decoder.
// Used by every module of the block; depends on nothing.
package pcfd_pkg;

    localparam int CAPTURE_BITS_DEF = 16;
    localparam int FRAME_SHIFT      = 5;
    localparam int VALUE_W          = 11;
    localparam int INDEX_W          = 6;
    localparam int COUNT_W          = 32;
    localparam int TIME_W           = 16;
    localparam int ADDR_W           = 4;
    localparam int DATA_W           = 32;

    localparam logic [INDEX_W-1:0] INDEX_LIMIT   = 6'd32;
    localparam logic [TIME_W-1:0]  GAP_LIMIT_RST = 16'd182;
    localparam logic [TIME_W-1:0]  THRESH_RST    = 16'd80;
    localparam logic [INDEX_W-1:0] EXPECT_RST    = 6'd15;

    typedef enum logic [1:0] {
        REG_GAP_LIMIT  = 2'd0,
        REG_THRESHOLD  = 2'd1,
        REG_EXPECT_CNT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [TIME_W-1:0]  gap_cycle_limit;
        logic [TIME_W-1:0]  one_high_threshold;
        logic [INDEX_W-1:0] expected_bit_count;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] cycle_time;
        logic [TIME_W-1:0] high_time;
    } t_in_word;

    typedef struct packed {
        logic               frame_ok;
        logic [VALUE_W-1:0] frame_value;
        logic [COUNT_W-1:0] good_frames;
        logic [COUNT_W-1:0] bad_frames;
    } t_out_word;

endpackage

// File: rtl/pcfd_cfg.sv
// Configuration register file with an APB-style slave port.
// Depends on pcfd_pkg for the register struct and index codes.
module pcfd_cfg import pcfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_cycle_limit    <= GAP_LIMIT_RST;
            r_cfg.one_high_threshold <= THRESH_RST;
            r_cfg.expected_bit_count <= EXPECT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_GAP_LIMIT:  r_cfg.gap_cycle_limit    <= pwdata[TIME_W-1:0];
                REG_THRESHOLD:  r_cfg.one_high_threshold <= pwdata[TIME_W-1:0];
                REG_EXPECT_CNT: r_cfg.expected_bit_count <= pwdata[INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GAP_LIMIT:  prdata = DATA_W'(r_cfg.gap_cycle_limit);
            REG_THRESHOLD:  prdata = DATA_W'(r_cfg.one_high_threshold);
            REG_EXPECT_CNT: prdata = DATA_W'(r_cfg.expected_bit_count);
            default:        prdata = '0;
        endcase
    end

endmodule

// File: rtl/pcfd_core.sv
// Decode datapath: input register, bit/gap decode, frame state and result register.
// Depends on pcfd_pkg for the word structs and constants.
module pcfd_core import pcfd_pkg::*; #(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    logic                    r_in_valid;
    t_in_word                r_in;
    logic [CAPTURE_BITS-1:0] r_bit_word, n_bit_word;
    logic [INDEX_W-1:0]      r_bit_index, n_bit_index;
    logic [COUNT_W-1:0]      r_good, n_good;
    logic [COUNT_W-1:0]      r_bad, n_bad;
    logic                    r_out_valid;
    t_out_word               r_out, n_out;

    logic               w_gap, w_one, w_match, w_out_free, w_fire;
    logic [VALUE_W-1:0] w_value;

    assign w_gap      = r_in.cycle_time >= i_cfg.gap_cycle_limit;
    assign w_one      = r_in.high_time > i_cfg.one_high_threshold;
    assign w_match    = r_bit_index == i_cfg.expected_bit_count;
    assign w_out_free = !r_out_valid || !i_out_stall;
    // a data bit always retires; a gap waits for room in the result register
    assign w_fire     = r_in_valid && (!w_gap || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;

    // first received bits, MSB first: bit-reverse within the capture width, drop five
    genvar j;
    generate
        for (j = 0; j < VALUE_W; j++) begin : g_value
            if (CAPTURE_BITS - 1 - FRAME_SHIFT - j >= 0) begin : g_tap
                assign w_value[j] = r_bit_word[CAPTURE_BITS - 1 - FRAME_SHIFT - j];
            end else begin : g_zero
                assign w_value[j] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        n_bit_word  = r_bit_word;
        n_bit_index = r_bit_index;
        n_good      = r_good;
        n_bad       = r_bad;
        if (w_fire && !w_gap) begin
            if (r_bit_index < INDEX_LIMIT) begin
                for (int k = 0; k < CAPTURE_BITS; k++) begin
                    if (w_one && r_bit_index == INDEX_W'(k)) begin
                        n_bit_word[k] = 1'b1;
                    end
                end
                n_bit_index = r_bit_index + 1'b1;
            end
        end else if (w_fire && w_gap) begin
            n_bit_word  = '0;
            n_bit_index = '0;
            n_good      = r_good + COUNT_W'(w_match);
            n_bad       = r_bad + COUNT_W'(!w_match);
        end
    end

    always_comb begin
        n_out.frame_ok    = w_match;
        n_out.frame_value = w_match ? w_value : '0;
        n_out.good_frames = n_good;
        n_out.bad_frames  = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_bit_word  <= '0;
            r_bit_index <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_bit_word  <= n_bit_word;
            r_bit_index <= n_bit_index;
            r_good      <= n_good;
            r_bad       <= n_bad;
            if (w_fire && w_gap) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_word;
        end
        if (w_fire && w_gap) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= INDEX_LIMIT)
        else $error("bit index beyond limit");

    a_gap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_gap) |=> (r_bit_index == '0 && r_bit_word == '0))
        else $error("frame state not cleared after gap");

    a_one_count_per_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_gap) |=>
            (COUNT_W'(r_good + r_bad) == COUNT_W'($past(r_good) + $past(r_bad) + 1'b1)))
        else $error("frame counters did not advance by one");

    a_reject_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.frame_ok) |-> (r_out.frame_value == '0))
        else $error("rejected frame carries a value");

    a_bits_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_gap && !r_out_valid) |=> !r_out_valid)
        else $error("data bit produced a result");
`endif

endmodule

// File: rtl/pulse_capture_frame_decoder_core.sv
// Pulse capture frame decoder: takes one captured pulse word (cycle time, high time) per
// cycle unless the input is stalled. Short cycles are data bits, a cycle at or above the
// gap limit ends the frame and yields one result word with the frame status, the first
// eleven bits MSB first, and the running good/bad frame counts. Throughput is one input
// word per clock while not stalled; a result word passes from its gap word through the
// input register, then the result register. Input stalls only while a gap word waits in
// the input register behind a full result register whose output is stalled.
// Depends on pcfd_pkg, pcfd_cfg and pcfd_core.
module pulse_capture_frame_decoder_core import pcfd_pkg::*; #(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    input  t_in_word          i_in_word,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_word         o_out_word,
    input  logic              i_out_stall
);

    t_cfg w_cfg;

    pcfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pcfd_core #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule
